### rtl/core/sparse_pixel_priority_merge_core_assert.svh
// assertion macros for the sparse pixel priority merge core
// used by the port checker, needs clk and rst_n in scope
`ifndef SPARSE_PIXEL_PRIORITY_MERGE_CORE_ASSERT_SVH
`define SPARSE_PIXEL_PRIORITY_MERGE_CORE_ASSERT_SVH

// same-cycle implication
`define SPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/spm_pkg.sv
// shared types, codes and constants of the sparse pixel priority merge core
// no dependencies
package spm_pkg;

  localparam int unsigned MAX_PIXELS_DEF   = 65536;
  localparam int unsigned MAX_CHANNELS_DEF = 8;

  localparam logic [15:0] UNCLAIMED  = 16'hFFFF;
  localparam logic [31:0] DEPTH_INF  = 32'h7F80_0000;
  localparam int unsigned LIMIT_W    = 33;

  localparam logic [1:0] CFG_DEPTH_MODE    = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] CFG_ZERO_OK       = 2'd2;
  localparam logic [1:0] CFG_PIXEL_COUNT   = 2'd3;

  typedef enum logic [2:0] {
    ST_WRITTEN = 3'd0,
    ST_KEPT    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_ZERO    = 3'd3,
    ST_DEPTH   = 3'd4,
    ST_HALTED  = 3'd5,
    ST_READ    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_READ_RANGE,
    CMD_MERGE_PRIO,
    CMD_MERGE_DEPTH,
    CMD_REJ_ZERO,
    CMD_REJ_RANGE,
    CMD_REJ_DEPTH
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP
  } bk_state_t;

  typedef struct packed {
    logic        depth_mode;
    logic [3:0]  channel_count;
    logic        zero_ok;
    logic [16:0] pixel_count;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] index;
    logic [15:0] ordinal;
    logic [31:0] depth;
    logic [63:0] data;
  } item_t;

  typedef struct packed {
    logic [63:0] pixel;
    logic [15:0] owner;
    logic [31:0] depth;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{pixel: 64'd0, owner: UNCLAIMED, depth: DEPTH_INF};

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

### rtl/core/spm_queue.sv
// two-entry item queue between the classify front and the merge back end
// depends on spm_pkg
module spm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  spm_pkg::item_t      push_item,
  input  logic                pop,
  output spm_pkg::item_t      head_item,
  output spm_pkg::queue_stat_t stat
);

  spm_pkg::item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = slot_r[rd_ptr_r];
  assign stat.full  = count_r[1];
  assign stat.valid = (count_r != 2'd0);

endmodule

### rtl/core/spm_front.sv
// input side: takes items, checks range, zero score and depth, masks channel bytes
// depends on spm_pkg, feeds spm_queue
module spm_front #(
  parameter int unsigned MAX_PIXELS   = spm_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_CHANNELS = spm_pkg::MAX_CHANNELS_DEF
) (
  input  spm_pkg::cfg_t        cfg,
  input  logic                 clearing,
  input  spm_pkg::queue_stat_t q_stat,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [31:0]          in_pixel_index,
  input  logic [15:0]          in_source_ordinal,
  input  logic [31:0]          in_depth_bits,
  input  logic [63:0]          in_channel_data,
  output logic                 push,
  output spm_pkg::item_t       push_item
);

  localparam logic [3:0] CHAN_MAX = 4'(MAX_CHANNELS);
  localparam logic [spm_pkg::LIMIT_W-1:0] PIX_MAX = spm_pkg::LIMIT_W'(MAX_PIXELS);

  logic [3:0]                  chans;
  logic [spm_pkg::LIMIT_W-1:0] limit;
  logic                        in_range;
  logic                        zero_score;
  logic                        bad_depth;
  logic [63:0]                 data_masked;
  spm_pkg::cmd_t               cmd;

  always_comb begin
    if (cfg.channel_count == 4'd0) begin
      chans = 4'd1;
    end else if (cfg.channel_count > CHAN_MAX) begin
      chans = CHAN_MAX;
    end else begin
      chans = cfg.channel_count;
    end

    if (spm_pkg::LIMIT_W'(cfg.pixel_count) > PIX_MAX) begin
      limit = PIX_MAX;
    end else begin
      limit = spm_pkg::LIMIT_W'(cfg.pixel_count);
    end
    in_range = spm_pkg::LIMIT_W'(in_pixel_index) < limit;

    for (int k = 0; k < 8; k++) begin
      data_masked[8*k +: 8] = (4'(k) < chans) ? in_channel_data[8*k +: 8] : 8'd0;
    end

    zero_score = !cfg.zero_ok && (chans == 4'd1) && (in_channel_data[7:0] == 8'd0);
    bad_depth  = (in_depth_bits == 32'd0) || (in_depth_bits >= spm_pkg::DEPTH_INF);

    priority if (in_req_type) begin
      cmd = in_range ? spm_pkg::CMD_READ : spm_pkg::CMD_READ_RANGE;
    end else if (!cfg.depth_mode) begin
      priority if (zero_score) begin
        cmd = spm_pkg::CMD_REJ_ZERO;
      end else if (!in_range) begin
        cmd = spm_pkg::CMD_REJ_RANGE;
      end else begin
        cmd = spm_pkg::CMD_MERGE_PRIO;
      end
    end else begin
      priority if (!in_range) begin
        cmd = spm_pkg::CMD_REJ_RANGE;
      end else if (bad_depth) begin
        cmd = spm_pkg::CMD_REJ_DEPTH;
      end else begin
        cmd = spm_pkg::CMD_MERGE_DEPTH;
      end
    end
  end

  assign in_stall          = clearing || q_stat.full;
  assign push              = in_valid && !in_stall;
  assign push_item.cmd     = cmd;
  assign push_item.index   = in_pixel_index;
  assign push_item.ordinal = in_source_ordinal;
  assign push_item.depth   = in_depth_bits;
  assign push_item.data    = data_masked;

endmodule

### rtl/core/spm_back.sv
// merge side: pixel memory with clear pass, read-modify-write, error latch, result register
// depends on spm_pkg, drains spm_queue
module spm_back #(
  parameter int unsigned MAX_PIXELS = spm_pkg::MAX_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spm_pkg::queue_stat_t q_stat,
  input  spm_pkg::item_t       head_item,
  output logic                 pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [63:0]          out_pixel_value,
  output logic                 out_failed
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

  spm_pkg::entry_t mem [MAX_PIXELS];
  spm_pkg::entry_t rd_data_r;

  spm_pkg::bk_state_t state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  spm_pkg::item_t     cur_r, cur_nxt;
  logic               error_r, error_nxt;
  logic               out_valid_r, out_valid_nxt;
  spm_pkg::status_t   out_status_r, out_status_nxt;
  logic [63:0]        out_value_r, out_value_nxt;
  logic               out_failed_r, out_failed_nxt;

  logic               out_free;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  spm_pkg::entry_t    mem_wdata;
  spm_pkg::status_t   status_c;
  logic [63:0]        value_c;
  logic               err_c;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cur_nxt        = cur_r;
    error_nxt      = error_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_failed_nxt = out_failed_r;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur_r.index[AW-1:0];
    mem_wdata      = rd_data_r;
    status_c       = spm_pkg::ST_KEPT;
    value_c        = 64'd0;
    err_c          = 1'b0;

    unique case (state_r)
      spm_pkg::BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = spm_pkg::ENTRY_RESET;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = spm_pkg::BK_IDLE;
        end
      end
      spm_pkg::BK_IDLE: begin
        if (q_stat.valid && out_free) begin
          pop       = 1'b1;
          cur_nxt   = head_item;
          state_nxt = spm_pkg::BK_LOOKUP;
        end
      end
      spm_pkg::BK_LOOKUP: begin
        if (cur_r.cmd == spm_pkg::CMD_READ) begin
          status_c = spm_pkg::ST_READ;
          value_c  = rd_data_r.pixel;
        end else if (cur_r.cmd == spm_pkg::CMD_READ_RANGE) begin
          status_c = spm_pkg::ST_RANGE;
        end else if (error_r) begin
          status_c = spm_pkg::ST_HALTED;
        end else begin
          unique case (cur_r.cmd)
            spm_pkg::CMD_REJ_ZERO: begin
              status_c = spm_pkg::ST_ZERO;
              err_c    = 1'b1;
            end
            spm_pkg::CMD_REJ_RANGE: begin
              status_c = spm_pkg::ST_RANGE;
              err_c    = 1'b1;
            end
            spm_pkg::CMD_REJ_DEPTH: begin
              status_c = spm_pkg::ST_DEPTH;
              err_c    = 1'b1;
            end
            spm_pkg::CMD_MERGE_PRIO: begin
              if (cur_r.ordinal < rd_data_r.owner) begin
                status_c        = spm_pkg::ST_WRITTEN;
                mem_we          = 1'b1;
                mem_wdata.owner = cur_r.ordinal;
                mem_wdata.pixel = cur_r.data;
              end
            end
            spm_pkg::CMD_MERGE_DEPTH: begin
              if (cur_r.depth < rd_data_r.depth) begin
                status_c        = spm_pkg::ST_WRITTEN;
                mem_we          = 1'b1;
                mem_wdata.depth = cur_r.depth;
                mem_wdata.pixel = cur_r.data;
              end
            end
            default: begin
              status_c = spm_pkg::ST_KEPT;
            end
          endcase
        end
        error_nxt      = error_r || err_c;
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_c;
        out_value_nxt  = value_c;
        out_failed_nxt = error_r || err_c;
        state_nxt      = spm_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = spm_pkg::BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spm_pkg::BK_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      error_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      error_r     <= error_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_failed_r <= out_failed_nxt;
  end

  // single-port pixel memory, read data registered on pop
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data_r <= mem[head_item.index[AW-1:0]];
    end
  end

  assign clearing        = (state_r == spm_pkg::BK_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pixel_value = out_value_r;
  assign out_failed      = out_failed_r;

endmodule

### rtl/core/sparse_pixel_priority_merge_core.sv
// sparse pixel priority merge core: the back end takes one item at a time through
// the read-modify-write on the single-port pixel memory
// path of an item: queue slot, item and read data registers, result register
// reset: synchronous active low, then a clear pass over all MAX_PIXELS entries
// (65536 by default) with in_stall high; config writes are taken throughout
// top level: config registers, front, queue and back end
module sparse_pixel_priority_merge_core #(
  parameter int unsigned MAX_PIXELS   = spm_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_CHANNELS = spm_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_pixel_index,
  input  logic [15:0] in_source_ordinal,
  input  logic [31:0] in_depth_bits,
  input  logic [63:0] in_channel_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_pixel_value,
  output logic        out_failed
);

  spm_pkg::cfg_t        cfg_r, cfg_nxt;
  spm_pkg::queue_stat_t q_stat;
  spm_pkg::item_t       push_item;
  spm_pkg::item_t       head_item;
  logic                 push;
  logic                 pop;
  logic                 clearing;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spm_pkg::CFG_DEPTH_MODE:    cfg_nxt.depth_mode    = cfg_data[0];
        spm_pkg::CFG_CHANNEL_COUNT: cfg_nxt.channel_count = cfg_data[3:0];
        spm_pkg::CFG_ZERO_OK:       cfg_nxt.zero_ok       = cfg_data[0];
        spm_pkg::CFG_PIXEL_COUNT:   cfg_nxt.pixel_count   = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode    <= 1'b0;
      cfg_r.channel_count <= 4'd1;
      cfg_r.zero_ok       <= 1'b0;
      cfg_r.pixel_count   <= 17'd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spm_front #(
    .MAX_PIXELS   (MAX_PIXELS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .cfg               (cfg_r),
    .clearing          (clearing),
    .q_stat            (q_stat),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_pixel_index    (in_pixel_index),
    .in_source_ordinal (in_source_ordinal),
    .in_depth_bits     (in_depth_bits),
    .in_channel_data   (in_channel_data),
    .push              (push),
    .push_item         (push_item)
  );

  spm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  spm_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_item       (head_item),
    .pop             (pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_pixel_value (out_pixel_value),
    .out_failed      (out_failed)
  );

endmodule

### rtl/core/spm_checker.sv
// port-level checker for the sparse pixel priority merge core, bound to the top level
// depends on spm_pkg and sparse_pixel_priority_merge_core_assert.svh
`include "sparse_pixel_priority_merge_core_assert.svh"

module spm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [63:0] out_pixel_value,
  input logic        out_failed
);

  `SPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_pixel_value), "stalled item changed")
  `SPM_ASSERT_NOW(a_status_code, out_valid, out_status <= spm_pkg::ST_READ, "status code out of range")
  `SPM_ASSERT_NOW(a_value_zero, out_valid && (out_status != spm_pkg::ST_READ), out_pixel_value == 64'd0, "nonzero value on non-read item")
  `SPM_ASSERT_NOW(a_fail_flag, out_valid && ((out_status == spm_pkg::ST_HALTED) || (out_status == spm_pkg::ST_ZERO) || (out_status == spm_pkg::ST_DEPTH)), out_failed, "error status without failed flag")

endmodule

bind sparse_pixel_priority_merge_core spm_checker u_spm_checker (.*);

### bench/spm_merge_check_pkg.sv
// expected-result tracking for the sparse pixel priority merge core bench
// keeps its own copy of the pixel, owner and depth stores and the registers
// depends on spm_pkg for the status codes, register indexes and constants
package spm_merge_check_pkg;
  import spm_pkg::*;

  typedef struct {
    status_t     status;
    logic [63:0] pixel;
    logic        failed;
  } merge_result_t;

  class pixel_merge_tracker;
    cfg_t          regs;
    logic [63:0]   pixels [int unsigned];
    logic [15:0]   owners [int unsigned];
    logic [31:0]   depths [int unsigned];
    bit            halted;
    merge_result_t pending_results[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   status_count [7];

    function new();
      regs = '{depth_mode: 1'b0, channel_count: 4'd1, zero_ok: 1'b0,
               pixel_count: 17'd65536};
      halted = 1'b0;
      mismatches = 0;
      results_seen = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [16:0] value);
      case (index)
        CFG_DEPTH_MODE:    regs.depth_mode    = value[0];
        CFG_CHANNEL_COUNT: regs.channel_count = value[3:0];
        CFG_ZERO_OK:       regs.zero_ok       = value[0];
        CFG_PIXEL_COUNT:   regs.pixel_count   = value;
        default: ;
      endcase
    endfunction

    function int unsigned lanes();
      int unsigned c;
      c = regs.channel_count;
      if (c < 1) c = 1;
      if (c > MAX_CHANNELS_DEF) c = MAX_CHANNELS_DEF;
      return c;
    endfunction

    function int unsigned limit();
      return (regs.pixel_count > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : regs.pixel_count;
    endfunction

    // accepted input item: work out its result and update the stores
    function void note_item(logic read_req, logic [31:0] index, logic [15:0] ordinal,
                            logic [31:0] depth, logic [63:0] data);
      merge_result_t r;
      logic [63:0]   kept_bytes;
      logic [15:0]   owner;
      logic [31:0]   nearest;
      bit            in_range;
      int unsigned   n;
      n = lanes();
      in_range = index < limit();
      kept_bytes = (n >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
      kept_bytes = kept_bytes & data;
      owner = owners.exists(index) ? owners[index] : UNCLAIMED;
      nearest = depths.exists(index) ? depths[index] : DEPTH_INF;
      r.pixel = '0;
      if (read_req) begin
        if (in_range) begin
          r.status = ST_READ;
          r.pixel = pixels.exists(index) ? pixels[index] : 64'd0;
        end else begin
          r.status = ST_RANGE;
        end
      end else if (halted) begin
        r.status = ST_HALTED;
      end else if (!regs.depth_mode) begin
        if (!regs.zero_ok && n == 1 && data[7:0] == 8'd0) begin
          r.status = ST_ZERO;
          halted = 1'b1;
        end else if (!in_range) begin
          r.status = ST_RANGE;
          halted = 1'b1;
        end else if (ordinal < owner) begin
          owners[index] = ordinal;
          pixels[index] = kept_bytes;
          r.status = ST_WRITTEN;
        end else begin
          r.status = ST_KEPT;
        end
      end else begin
        if (!in_range) begin
          r.status = ST_RANGE;
          halted = 1'b1;
        end else if (depth == 32'd0 || depth >= DEPTH_INF) begin
          r.status = ST_DEPTH;
          halted = 1'b1;
        end else if (depth < nearest) begin
          depths[index] = depth;
          pixels[index] = kept_bytes;
          r.status = ST_WRITTEN;
        end else begin
          r.status = ST_KEPT;
        end
      end
      r.failed = halted;
      status_count[r.status]++;
      pending_results.push_back(r);
    endfunction

    function void check_item(logic [2:0] status, logic [63:0] pixel, logic failed);
      merge_result_t w;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d pixel %h failed %b", status, pixel, failed);
        return;
      end
      w = pending_results.pop_front();
      if (status !== w.status || pixel !== w.pixel || failed !== w.failed) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: expected status %0d pixel %h failed %b",
                   results_seen, w.status, w.pixel, w.failed);
          $display("  got status %0d pixel %h failed %b", status, pixel, failed);
        end
      end
    endfunction
  endclass

endpackage

### bench/tb.sv
// top-level bench for sparse_pixel_priority_merge_core: directed and random
// merge and read items under random idling, checked against a tracked copy
// depends on spm_pkg and spm_merge_check_pkg
module tb;
  import spm_pkg::*;
  import spm_merge_check_pkg::*;

  localparam logic REQ_MERGE = 1'b0;
  localparam logic REQ_READ  = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_DEPTH_MODE;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = REQ_MERGE;
  logic [31:0] in_pixel_index = '0;
  logic [15:0] in_source_ordinal = '0;
  logic [31:0] in_depth_bits = '0;
  logic [63:0] in_channel_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_pixel_value;
  logic        out_failed;

  pixel_merge_tracker tracker = new();
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned items_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;

  sparse_pixel_priority_merge_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_pixel_index(in_pixel_index), .in_source_ordinal(in_source_ordinal),
    .in_depth_bits(in_depth_bits), .in_channel_data(in_channel_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_pixel_value(out_pixel_value), .out_failed(out_failed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_item(out_status, out_pixel_value, out_failed);
  end

  // result side stall, long hold when asked
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        wait_left = 300;
        hold_request = 1'b0;
      end else if (out_valid && !out_stall) begin
        wait_left = rx_calm ? 0 : $urandom_range(0, 17);
      end
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_regs(input logic mode, input logic [3:0] chans, input logic az,
                            input logic [16:0] count);
    logic [16:0] vals [4];
    vals[CFG_DEPTH_MODE]    = {16'd0, mode};
    vals[CFG_CHANNEL_COUNT] = {13'd0, chans};
    vals[CFG_ZERO_OK]       = {16'd0, az};
    vals[CFG_PIXEL_COUNT]   = count;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.write_reg(i[1:0], vals[i]);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic read_req, input logic [31:0] index,
                           input logic [15:0] ordinal, input logic [31:0] depth,
                           input logic [63:0] data);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= read_req;
    in_pixel_index <= index;
    in_source_ordinal <= ordinal;
    in_depth_bits <= depth;
    in_channel_data <= data;
    do @(posedge clk); while (in_stall);
    tracker.note_item(read_req, index, ordinal, depth, data);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  // merges stay legal under the current registers; misses are reads only
  task automatic send_random_items(input int unsigned count);
    logic        read_req;
    logic [31:0] index;
    logic [31:0] depth;
    logic [15:0] ordinal;
    logic [63:0] data;
    int unsigned lim;
    int unsigned roll;
    repeat (count) begin
      lim = tracker.limit();
      roll = $urandom_range(0, 99);
      data = {$urandom, $urandom};
      if ($urandom_range(0, 5) == 0) data[7:0] = 8'd0;
      ordinal = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      case ($urandom_range(0, 7))
        0, 1, 2, 3: depth = $urandom_range(1, 40);
        4: depth = 32'h7F7F_FFFF;
        5: depth = 32'd1;
        default: depth = $urandom_range(1, 32'h7F7F_FFFF);
      endcase
      if (lim == 0 || roll < 12) begin
        read_req = REQ_READ;
        if (roll % 2 == 0) begin
          index = lim + $urandom_range(0, 3);
        end else begin
          index = $urandom;
          if (index < lim) index = index | 32'h8000_0000;
        end
      end else begin
        read_req = (roll < 30) ? REQ_READ : REQ_MERGE;
        if (roll % 5 == 0) index = lim - 1;
        else if (roll % 7 == 0) index = $urandom_range(0, lim - 1);
        else index = $urandom_range(0, ((lim < 48) ? lim : 48) - 1);
      end
      if (read_req == REQ_READ) begin
        ordinal = 16'($urandom);
        depth = $urandom;
      end else if (!tracker.regs.depth_mode) begin
        depth = $urandom;
        if (tracker.lanes() == 1 && !tracker.regs.zero_ok && data[7:0] == 8'd0)
          data[7:0] = 8'($urandom_range(1, 255));
      end
      send_item(read_req, index, ordinal, depth, data);
    end
  endtask

  task automatic random_phase(input int unsigned count);
    logic [3:0]  chans;
    logic [16:0] pc;
    case ($urandom_range(0, 5))
      0: chans = 4'd0;
      1: chans = 4'd1;
      2: chans = 4'd8;
      3: chans = 4'd15;
      default: chans = 4'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 9))
      0: pc = 17'd0;
      1: pc = 17'd65536;
      2: pc = 17'h1FFFF;
      3: pc = 17'd1;
      4: pc = 17'd65535;
      default: pc = 17'($urandom_range(2, 64));
    endcase
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    write_regs(1'($urandom_range(0, 1)), chans, 1'($urandom_range(0, 1)), pc);
    send_random_items(count);
    drain();
  endtask

  initial begin : stimulus
    status_t     fault;
    logic [31:0] index;
    logic [31:0] depth;
    logic [63:0] data;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // priority mode, full width pixels
    write_regs(1'b0, 4'd8, 1'b0, 17'd16);
    send_item(REQ_READ, 0, 16'd0, 32'd0, 64'd0);
    send_item(REQ_MERGE, 0, 16'd100, 32'd0, {64{1'b1}});
    send_item(REQ_MERGE, 0, 16'd100, 32'hFFFF_FFFF, 64'h1111_2222_3333_4444);
    send_item(REQ_MERGE, 0, UNCLAIMED, 32'd0, 64'h5555_6666_7777_8888);
    send_item(REQ_MERGE, 1, UNCLAIMED, 32'd0, 64'h9999_AAAA_BBBB_CCCC);
    send_item(REQ_MERGE, 0, 16'd0, 32'd0, 64'h0123_4567_89AB_CDEF);
    send_item(REQ_MERGE, 15, 16'd7, 32'd0, 64'hFEDC_BA98_7654_3200);
    send_item(REQ_READ, 15, 16'd0, 32'd0, 64'd0);
    send_item(REQ_READ, 0, 16'd0, 32'd0, 64'd0);
    send_item(REQ_READ, 16, 16'd0, 32'd0, 64'd0);
    send_item(REQ_READ, 32'hFFFF_FFFF, UNCLAIMED, 32'hFFFF_FFFF, {64{1'b1}});
    drain();

    // depth mode, saturated channel count and pixel count
    write_regs(1'b1, 4'd15, 1'b1, 17'h1FFFF);
    send_item(REQ_MERGE, 65535, 16'd0, 32'h7F7F_FFFF, 64'hA5A5_A5A5_A5A5_A5A5);
    send_item(REQ_MERGE, 65535, 16'd0, 32'h7F7F_FFFF, 64'h1234_5678_9ABC_DEF0);
    send_item(REQ_MERGE, 65535, 16'd0, 32'd1, 64'h0F0F_0F0F_0F0F_0F0F);
    send_item(REQ_MERGE, 0, 16'd0, 32'd5, 64'h00FF_00FF_00FF_00FF);
    send_item(REQ_READ, 65535, 16'd0, 32'd0, 64'd0);
    send_item(REQ_READ, 65536, 16'd0, 32'd0, 64'd0);
    drain();

    // no valid pixels: reads only
    write_regs(1'b0, 4'd0, 1'b1, 17'd0);
    send_item(REQ_READ, 0, 16'd0, 32'd0, 64'd0);
    drain();

    // single channel with zero allowed, upper bytes masked off
    write_regs(1'b0, 4'd0, 1'b1, 17'd8);
    send_item(REQ_MERGE, 3, 16'd1, 32'd0, 64'hFFFF_FFFF_FFFF_FF00);
    send_item(REQ_READ, 3, 16'd0, 32'd0, 64'd0);
    drain();

    repeat (14) random_phase(60);

    // long result hold with a steady sender so the input backs up
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    write_regs(1'b1, 4'd8, 1'b0, 17'd32);
    hold_request = 1'b1;
    send_random_items(40);
    drain();
    tx_calm = 1'b0;

    // one rejected merge, then everything after it halts
    case ($urandom_range(0, 2))
      0: fault = ST_ZERO;
      1: fault = ST_RANGE;
      default: fault = ST_DEPTH;
    endcase
    data = {$urandom, $urandom};
    case (fault)
      ST_ZERO: begin
        write_regs(1'b0, 4'd1, 1'b0, 17'd64);
        data[7:0] = 8'd0;
        index = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd5;
        send_item(REQ_MERGE, index, 16'($urandom), $urandom, data);
      end
      ST_RANGE: begin
        write_regs(1'($urandom_range(0, 1)), 4'd8, 1'b1, 17'd64);
        index = ($urandom_range(0, 1) == 1) ? (32'd64 + $urandom_range(0, 3))
                                            : ($urandom | 32'h8000_0000);
        send_item(REQ_MERGE, index, 16'd0, 32'd0, data);
      end
      default: begin
        write_regs(1'b1, 4'd8, 1'b0, 17'd64);
        case ($urandom_range(0, 4))
          0: depth = 32'd0;
          1: depth = 32'h8000_0000;
          2: depth = DEPTH_INF;
          3: depth = 32'h7FC0_0000;
          default: depth = 32'hFFFF_FFFF;
        endcase
        send_item(REQ_MERGE, 32'd2, 16'd0, depth, data);
      end
    endcase
    send_random_items(25);
    drain();
    repeat (8) @(posedge clk);

    $display("%0d items, %0d register writes, %0d results checked, %0d mismatches",
             items_sent, reg_writes, tracker.results_seen, tracker.mismatches);
    $display("written %0d kept %0d range %0d zero %0d depth %0d halted %0d read %0d",
             tracker.status_count[ST_WRITTEN], tracker.status_count[ST_KEPT],
             tracker.status_count[ST_RANGE], tracker.status_count[ST_ZERO],
             tracker.status_count[ST_DEPTH], tracker.status_count[ST_HALTED],
             tracker.status_count[ST_READ]);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/spm_pkg.sv
rtl/core/spm_queue.sv
rtl/core/spm_front.sv
rtl/core/spm_back.sv
rtl/core/sparse_pixel_priority_merge_core.sv
rtl/core/spm_checker.sv
bench/spm_merge_check_pkg.sv
bench/tb.sv
